/* rtl/bcw_pkg.sv */
// Package for the Becke cell weight unit: payload structs and constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package bcw_pkg;
  localparam int MaxCenters = 64;
  localparam int CoordBits  = 32;
  localparam int Frac       = 30;

  localparam logic KindLoad  = 1'b0;
  localparam logic KindQuery = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [5:0]  center_index;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
  } in_word_t;

  typedef struct packed {
    logic [30:0] weight;
    logic        coincident_error;
  } out_word_t;
endpackage
`default_nettype wire

/* rtl/bcw_arith.sv */
// Shared multi-cycle arithmetic: integer square root and restoring divider.
// Depends on bcw_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bcw_arith #(
  parameter int CoordBits = bcw_pkg::CoordBits
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic sqrt_start_i,
  input  wire logic [2*CoordBits+3:0] sqrt_arg_i,
  input  wire logic div_start_i,
  input  wire logic [CoordBits+2:0] div_num_i,
  input  wire logic [CoordBits+2:0] div_den_i,
  output logic busy_o,
  output logic [CoordBits+2:0] root_o,
  output logic [bcw_pkg::Frac-1:0] quot_o
);
  localparam int SW = 2*CoordBits+4;
  localparam int RW = CoordBits+2+1;
  localparam int SSteps = SW/2;
  localparam int CW = $clog2(SSteps+1);

  typedef enum logic [1:0] {AIdle, ASqrt, ADiv} astate_e;
  astate_e st_q;
  logic [CW-1:0] cnt_q;
  logic [SW-1:0] rad_q;
  logic [SW+1:0] rem_q;
  logic [RW-1:0] root_q;
  logic [RW:0] drem_q;
  logic [RW-1:0] den_q;
  logic [bcw_pkg::Frac-1:0] quo_q;

  logic [SW+1:0] rem_sh, trial;
  logic [RW:0] dsh;
  always_comb begin
    rem_sh = {rem_q[SW-1:0], rad_q[SW-1 -: 2]};
    trial  = {{(SW-RW){1'b0}}, root_q, 2'b01};
    dsh    = {drem_q[RW-1:0], 1'b0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= AIdle;
      cnt_q <= '0;
    end else begin
      case (st_q)
        AIdle: begin
          if (sqrt_start_i) begin
            st_q <= ASqrt; cnt_q <= CW'(SSteps);
            rad_q <= sqrt_arg_i; rem_q <= '0; root_q <= '0;
          end else if (div_start_i) begin
            st_q <= ADiv; cnt_q <= CW'(bcw_pkg::Frac);
            drem_q <= {1'b0, div_num_i}; den_q <= div_den_i; quo_q <= '0;
          end
        end
        ASqrt: begin
          rad_q <= {rad_q[SW-3:0], 2'b00};
          if (rem_sh >= trial) begin
            rem_q <= rem_sh - trial; root_q <= {root_q[RW-2:0], 1'b1};
          end else begin
            rem_q <= rem_sh; root_q <= {root_q[RW-2:0], 1'b0};
          end
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == CW'(1)) st_q <= AIdle;
        end
        ADiv: begin
          if (dsh >= {1'b0, den_q}) begin
            drem_q <= dsh - {1'b0, den_q}; quo_q <= {quo_q[bcw_pkg::Frac-2:0], 1'b1};
          end else begin
            drem_q <= dsh; quo_q <= {quo_q[bcw_pkg::Frac-2:0], 1'b0};
          end
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == CW'(1)) st_q <= AIdle;
        end
        default: st_q <= AIdle;
      endcase
    end
  end

  assign busy_o = (st_q != AIdle) || sqrt_start_i || div_start_i;
  assign root_o = root_q;
  assign quot_o = quo_q;
endmodule
`default_nettype wire

/* rtl/becke_cell_weight_unit.sv */
// Becke cell weight unit top level: center memory and query sequencer.
// Depends on bcw_pkg and bcw_arith.
`timescale 1ns / 1ps
`default_nettype none
// Load words write one center into the coordinate memory (one word per
// cycle while idle with no pending output, no result). A query word walks
// centers 0..center_count-1 (capped at MaxCenters) one at a time through a
// shared square-root / divider unit; each root runs CoordBits+2 steps plus
// issue and hand-off. A center costs the fetch, two roots, the division
// and the polynomial and product multiplies (no division when mu
// saturates, one root for a coincident center, nothing for the owner). A
// query adds a root for |r| plus loop exit and output. The next word is
// taken once the weight has left the output register.
module becke_cell_weight_unit #(
  parameter int MaxCenters = bcw_pkg::MaxCenters,
  parameter int CoordBits  = bcw_pkg::CoordBits
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic cfg_we_i,
  input  wire logic [6:0] cfg_wdata_i,
  input  wire logic in_valid_i,
  output logic in_ready_o,
  input  wire bcw_pkg::in_word_t in_data_i,
  output logic out_valid_o,
  input  wire logic out_ready_i,
  output bcw_pkg::out_word_t out_data_o
);
  localparam int AW = (MaxCenters > 1) ? $clog2(MaxCenters) : 1;
  localparam int CB = CoordBits;
  localparam int DW = CB+2;          // difference / sum width
  localparam int NW = CB+3;          // norm width
  localparam int SQW = 2*CB+4;
  localparam int F = bcw_pkg::Frac;
  localparam int CntCap = (MaxCenters < 127) ? MaxCenters : 127;
  localparam logic [F:0] One = {1'b1, {F{1'b0}}};
  localparam logic [F+1:0] Three = {2'b11, {F{1'b0}}};

  typedef enum logic [4:0] {
    SIdle, SNr, SNrW, SRd, SRdW, SDiff, SNd, SNdW, SNb, SNbW, SDiv, SDivW,
    SP1, SP2, SP3, SS, SProd, SNext, SOut
  } state_e;

  logic [CB-1:0] mem_x [MaxCenters];
  logic [CB-1:0] mem_y [MaxCenters];
  logic [CB-1:0] mem_z [MaxCenters];
  logic [CB-1:0] rd_x_q, rd_y_q, rd_z_q;
  logic [AW-1:0] rd_addr;
  logic rd_en;

  state_e st_q;
  logic [6:0] count_q;
  logic [AW-1:0] p_q;
  logic [AW:0] b_q, lim_q;
  logic signed [CB-1:0] rx_q, ry_q, rz_q, px_q, py_q, pz_q;
  logic signed [DW-1:0] dx_q, dy_q, dz_q;
  logic [NW-1:0] nr_q, nd_q, nb_q;
  logic neg_q, err_q;
  logic [F:0] fm_q;
  logic [F+1:0] m2_q;
  logic [1:0] it_q;
  logic [F:0] s_q, w_q;
  logic out_valid_q;
  bcw_pkg::out_word_t out_q;

  // arithmetic unit
  logic sq_start, dv_start, a_busy;
  logic [SQW-1:0] sq_arg;
  logic [NW-1:0] root, dnum;
  logic [F-1:0] quot;
  logic signed [DW-1:0] vx, vy, vz;
  logic [DW-1:0] ax, ay, az;
  logic [NW-1:0] amag;

  bcw_arith #(.CoordBits(CB)) u_arith (
    .clk_i, .rst_ni,
    .sqrt_start_i(sq_start), .sqrt_arg_i(sq_arg),
    .div_start_i(dv_start), .div_num_i(dnum), .div_den_i(nd_q),
    .busy_o(a_busy), .root_o(root), .quot_o(quot)
  );

  always_comb begin
    case (st_q)
      SNr:     begin vx = DW'(rx_q); vy = DW'(ry_q); vz = DW'(rz_q); end
      SNd:     begin vx = dx_q; vy = dy_q; vz = dz_q; end
      default: begin vx = dx_q + DW'(rx_q); vy = dy_q + DW'(ry_q); vz = dz_q + DW'(rz_q); end
    endcase
    ax = vx[DW-1] ? DW'(-vx) : DW'(vx);
    ay = vy[DW-1] ? DW'(-vy) : DW'(vy);
    az = vz[DW-1] ? DW'(-vz) : DW'(vz);
    sq_arg = SQW'({{DW{1'b0}}, ax} * {{DW{1'b0}}, ax}) + SQW'({{DW{1'b0}}, ay} * {{DW{1'b0}}, ay})
           + SQW'({{DW{1'b0}}, az} * {{DW{1'b0}}, az});
    sq_start = (st_q == SNr) || (st_q == SNd) || (st_q == SNb);
    amag = (nr_q < nb_q) ? nb_q - nr_q : nr_q - nb_q;
    dnum = amag;
    dv_start = (st_q == SDiv) && (amag < nd_q);
  end

  assign rd_en = (st_q == SRd);
  assign rd_addr = (st_q == SRd) ? b_q[AW-1:0] : p_q;

  // center memory, one write and one registered read port per table
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o && in_data_i.kind == bcw_pkg::KindLoad) begin
      mem_x[AW'(in_data_i.center_index)] <= CB'(in_data_i.coord_x);
      mem_y[AW'(in_data_i.center_index)] <= CB'(in_data_i.coord_y);
      mem_z[AW'(in_data_i.center_index)] <= CB'(in_data_i.coord_z);
    end
    if (rd_en || st_q == SNr) begin
      rd_x_q <= mem_x[rd_addr];
      rd_y_q <= mem_y[rd_addr];
      rd_z_q <= mem_z[rd_addr];
    end
  end

  logic [2*F+2:0] prod;
  always_comb begin
    case (st_q)
      SP1:     prod = (2*F+3)'(fm_q) * (2*F+3)'(fm_q);
      SP2:     prod = (2*F+3)'(fm_q) * (2*F+3)'(Three - m2_q);
      default: prod = (2*F+3)'(w_q) * (2*F+3)'(s_q);
    endcase
  end

  assign in_ready_o = (st_q == SIdle) && !out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle;
      count_q <= 7'd1;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) count_q <= cfg_wdata_i;
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      case (st_q)
        SIdle: begin
          if (in_valid_i && in_ready_o && in_data_i.kind == bcw_pkg::KindQuery) begin
            p_q <= AW'(in_data_i.center_index);
            rx_q <= CB'(in_data_i.coord_x);
            ry_q <= CB'(in_data_i.coord_y);
            rz_q <= CB'(in_data_i.coord_z);
            lim_q <= (count_q > 7'(CntCap)) ? (AW+1)'(CntCap)
                                            : (AW+1)'(count_q);
            b_q <= '0; w_q <= One; err_q <= 1'b0;
            st_q <= SNr;
          end
        end
        SNr: st_q <= SNrW;   // p entry read here as well
        SNrW: begin
          if (!a_busy) begin
            nr_q <= root;
            px_q <= rd_x_q; py_q <= rd_y_q; pz_q <= rd_z_q;
            st_q <= SNext;
          end
        end
        SNext: begin
          if (b_q >= lim_q) st_q <= SOut;
          else if (b_q[AW-1:0] == p_q) b_q <= b_q + 1'b1;
          else st_q <= SRd;
        end
        SRd: st_q <= SRdW;
        SRdW: st_q <= SDiff;
        SDiff: begin
          dx_q <= DW'(px_q) - DW'($signed(rd_x_q));
          dy_q <= DW'(py_q) - DW'($signed(rd_y_q));
          dz_q <= DW'(pz_q) - DW'($signed(rd_z_q));
          st_q <= SNd;
        end
        SNd: st_q <= SNdW;
        SNdW: if (!a_busy) begin
          nd_q <= root;
          if (root == '0) begin
            err_q <= 1'b1; b_q <= b_q + 1'b1; st_q <= SNext;
          end else st_q <= SNb;
        end
        SNb: st_q <= SNbW;
        SNbW: if (!a_busy) begin nb_q <= root; st_q <= SDiv; end
        SDiv: begin
          neg_q <= nr_q < nb_q;
          st_q <= (amag < nd_q) ? SDivW : SP1;
          if (amag >= nd_q) fm_q <= One;
          it_q <= '0;
        end
        SDivW: if (!a_busy) begin fm_q <= {1'b0, quot}; st_q <= SP1; end
        SP1: begin m2_q <= (F+2)'(prod >> F); st_q <= SP2; end
        SP2: begin
          fm_q <= (F+1)'(prod >> (F+1));
          it_q <= it_q + 1'b1;
          st_q <= (it_q == 2'd2) ? SS : SP1;
        end
        SS: begin
          s_q <= neg_q ? (F+1)'(({1'b0, One} + {1'b0, fm_q}) >> 1)
                       : (F+1)'((One - fm_q) >> 1);
          st_q <= SProd;
        end
        SProd: begin
          w_q <= (F+1)'(prod >> F);
          b_q <= b_q + 1'b1;
          st_q <= SNext;
        end
        SOut: begin
          if (!out_valid_q) begin
            out_q.weight <= err_q ? '0 : w_q;
            out_q.coincident_error <= err_q;
            out_valid_q <= 1'b1;
            st_q <= SIdle;
          end
        end
        default: st_q <= SIdle;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;
endmodule
`default_nettype wire
